@@ rtl/mh64_pkg.sv @@
// Shared constants, codes, types and helper functions for the MetroHash64 stream hasher.
// No dependencies; every other file of the block refers to it by scoped names.
package mh64_pkg;

  // Default width of the stored message length and byte offset.
  localparam int unsigned DEFAULT_LENGTH_BITS = 32;

  // Hash multipliers.
  localparam logic [31:0] K0 = 32'hC83A_91E1;
  localparam logic [31:0] K1 = 32'h8648_DBDB;
  localparam logic [31:0] K2 = 32'h7BDE_C03B;
  localparam logic [31:0] K3 = 32'h2F58_70A5;

  // Multiplier constant selects. The stripe lane number doubles as a select.
  localparam logic [1:0] KS0 = 2'd0;
  localparam logic [1:0] KS1 = 2'd1;
  localparam logic [1:0] KS2 = 2'd2;
  localparam logic [1:0] KS3 = 2'd3;

  // Remainder piece codes: a whole word, or a 4, 2 or 1 byte tail piece.
  localparam logic [1:0] PC_WORD = 2'd0;
  localparam logic [1:0] PC_4    = 2'd1;
  localparam logic [1:0] PC_2    = 2'd2;
  localparam logic [1:0] PC_1    = 2'd3;

  // Finished hash handed from the sequencer to the output register.
  typedef struct packed {
    logic        valid;
    logic [63:0] hash;
  } res_t;

  function automatic logic [31:0] k_const(input logic [1:0] ks);
    logic [31:0] k;
    case (ks)
      KS0:     k = K0;
      KS1:     k = K1;
      KS2:     k = K2;
      default: k = K3;
    endcase
    return k;
  endfunction

  function automatic logic [63:0] rotr64(input logic [63:0] v, input int unsigned k);
    return (v >> k) | (v << (64 - k));
  endfunction

  // Rotation used after the add of each remainder piece.
  function automatic logic [63:0] rot_piece(input logic [63:0] v, input logic [1:0] pc);
    logic [63:0] r;
    case (pc)
      PC_WORD: r = rotr64(v, 33);
      PC_4:    r = rotr64(v, 15);
      PC_2:    r = rotr64(v, 13);
      default: r = rotr64(v, 25);
    endcase
    return r;
  endfunction

  function automatic logic [63:0] piece_mask(input logic [1:0] pc);
    logic [63:0] m;
    case (pc)
      PC_WORD: m = '1;
      PC_4:    m = 64'h0000_0000_FFFF_FFFF;
      PC_2:    m = 64'h0000_0000_0000_FFFF;
      default: m = 64'h0000_0000_0000_00FF;
    endcase
    return m;
  endfunction

  // Tail bytes a piece consumes. A whole word is never part of a tail, so it counts zero.
  function automatic logic [2:0] piece_len(input logic [1:0] pc);
    logic [2:0] n;
    case (pc)
      PC_WORD: n = 3'd0;
      PC_4:    n = 3'd4;
      PC_2:    n = 3'd2;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [63:0] shift_piece(input logic [63:0] v, input logic [1:0] pc);
    logic [63:0] r;
    case (pc)
      PC_WORD: r = v;
      PC_4:    r = v >> 32;
      PC_2:    r = v >> 16;
      default: r = v >> 8;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/metrohash64_stream_hasher.sv @@
// Top level of the MetroHash64 stream hasher: seed register, output register, sequencer.
// Depends on mh64_pkg and instantiates mh64_seq.
//
// Usage. The seed is written over the cfg channel (cfg_valid_i, cfg_ready_o, cfg_data_i);
// cfg_ready_o is always high and the write should only be made while the block is idle.
// Message words enter on the input channel (in_valid_i, in_ready_o), one 64-bit word per
// handshake, little-endian. The first word of a message carries first_word_i and the total
// length in message_length_i; the bytes each word contributes follow from that length, so
// byte_count_i is informational only. The word that carries last_i yields one hash on the
// output channel (out_valid_o, out_ready_i, hash_value_o).
// Timing. A word occupies the single shared multiplier for its whole processing, and
// in_ready_o stays low meanwhile. A bulk stripe word takes one multiply and a lane
// update; the word that completes the last full stripe adds four fold rounds and a
// final add. The first word of a message adds the seed multiply. A whole remainder
// word takes a multiply, an add, a second multiply and an xor; the first word of a
// 16-byte pair or a word past the declared length takes no multiply, the second word
// of a pair six, and a partial tail word one such pass per 4/2/1-byte piece. A last
// word adds an avalanche multiply; the hash enters the output register once it has room.
// Reset clears all hash state and the seed to zero and drops out_valid_o. When the receiver
// stalls, the finished hash waits in the output register while the next message words are
// still taken; only a following hash waits until the register is free.
module metrohash64_stream_hasher #(
  parameter int unsigned LENGTH_BITS = mh64_pkg::DEFAULT_LENGTH_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        first_word_i,
  input  logic [31:0] message_length_i,
  input  logic [63:0] data_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] hash_value_o
);

  logic [63:0]    seed_q;
  logic           out_valid_q;
  logic [63:0]    hash_q;
  logic           res_ready;
  mh64_pkg::res_t res;

  // The seed register accepts a write on every cycle.
  assign cfg_ready_o = 1'b1;

  // The sequencer may hand over a hash whenever the output register is empty or draining.
  assign res_ready = !out_valid_q || out_ready_i;

  mh64_seq #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_seq (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .seed_i           (seed_q),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .first_word_i     (first_word_i),
    .message_length_i (message_length_i),
    .data_i           (data_i),
    .last_i           (last_i),
    .res_ready_i      (res_ready),
    .res_o            (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        seed_q <= cfg_data_i;
      end
      if (res.valid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      hash_q <= res.hash;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hash_value_o = hash_q;

endmodule

@@ rtl/mh64_mul.sv @@
// Shared registered multiplier: a 64-bit operand times one of the four 32-bit hash constants.
// Depends on mh64_pkg for the constant table.
module mh64_mul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] opa_i,
  input  logic [1:0]  ks_i,
  output logic [63:0] prod_o
);

  logic [31:0] k;
  logic [63:0] lo;
  logic [31:0] hi;
  logic [63:0] prod_d, prod_q;

  // The product modulo 2^64 is built from two 32x32 partial products.
  assign k      = mh64_pkg::k_const(ks_i);
  assign lo     = 64'(opa_i[31:0]) * 64'(k);
  assign hi     = 32'(opa_i[63:32] * k);
  assign prod_d = lo + {hi, 32'd0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

@@ rtl/mh64_seq.sv @@
// Sequencer and hash state of the MetroHash64 stream hasher: steps each word through the
// shared multiplier. Depends on mh64_pkg and instantiates mh64_mul.
module mh64_seq #(
  parameter int unsigned LENGTH_BITS = mh64_pkg::DEFAULT_LENGTH_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [63:0]        seed_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               first_word_i,
  input  logic [31:0]        message_length_i,
  input  logic [63:0]        data_i,
  input  logic               last_i,
  input  logic               res_ready_i,
  output mh64_pkg::res_t     res_o
);

  localparam int unsigned LW = LENGTH_BITS;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_INIT   = 5'd1;
  localparam logic [4:0] S_DISP   = 5'd2;
  localparam logic [4:0] S_STRIPE = 5'd3;
  localparam logic [4:0] S_P1     = 5'd4;
  localparam logic [4:0] S_P2     = 5'd5;
  localparam logic [4:0] S_P3     = 5'd6;
  localparam logic [4:0] S_P4     = 5'd7;
  localparam logic [4:0] S_P5     = 5'd8;
  localparam logic [4:0] S_P6     = 5'd9;
  localparam logic [4:0] S_TDISP  = 5'd10;
  localparam logic [4:0] S_TADD   = 5'd11;
  localparam logic [4:0] S_TXOR   = 5'd12;
  localparam logic [4:0] S_FA     = 5'd13;
  localparam logic [4:0] S_FB     = 5'd14;
  localparam logic [4:0] S_FC     = 5'd15;
  localparam logic [4:0] S_FH     = 5'd16;
  localparam logic [4:0] S_FIN    = 5'd17;
  localparam logic [4:0] S_AV     = 5'd18;

  localparam logic [1:0] LastRound = 2'd3;

  logic [4:0]    state_q, state_d;
  logic [63:0]   lane_q [4];
  logic [63:0]   lane_d [4];
  logic [63:0]   h_q, h_d;
  logic [63:0]   pair_q, pair_d;
  logic [LW-1:0] off_q, off_d;
  logic [LW-1:0] tot_q, tot_d;
  logic [63:0]   d_q, d_d;
  logic          last_q, last_d;
  logic [63:0]   a_q, a_d;
  logic [63:0]   b_q, b_d;
  logic [2:0]    n_q, n_d;
  logic [1:0]    piece_q, piece_d;
  logic [1:0]    rnd_q, rnd_d;

  logic          mul_en;
  logic [63:0]   mul_a;
  logic [1:0]    mul_ks;
  logic [63:0]   p;

  logic [LW-1:0] bulk_end, post, rem;
  logic [63:0]   sum, hs;
  logic [1:0]    pc_sel;

  mh64_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .opa_i  (mul_a),
    .ks_i   (mul_ks),
    .prod_o (p)
  );

  assign bulk_end = {tot_q[LW-1:5], 5'd0};
  assign post     = off_q - bulk_end;
  assign rem      = tot_q - off_q;
  assign pc_sel   = n_q[2] ? mh64_pkg::PC_4 : (n_q[1] ? mh64_pkg::PC_2 : mh64_pkg::PC_1);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    lane_d  = lane_q;
    h_d     = h_q;
    pair_d  = pair_q;
    off_d   = off_q;
    tot_d   = tot_q;
    d_d     = d_q;
    last_d  = last_q;
    a_d     = a_q;
    b_d     = b_q;
    n_d     = n_q;
    piece_d = piece_q;
    rnd_d   = rnd_q;
    mul_en  = 1'b0;
    mul_a   = '0;
    mul_ks  = mh64_pkg::KS0;
    sum     = '0;
    hs      = '0;
    res_o.valid = 1'b0;
    res_o.hash  = p ^ mh64_pkg::rotr64(p, 33);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          d_d    = data_i;
          last_d = last_i;
          if (first_word_i) begin
            tot_d   = LW'(message_length_i);
            off_d   = '0;
            pair_d  = '0;
            mul_en  = 1'b1;
            mul_a   = seed_i + 64'(mh64_pkg::K2);
            mul_ks  = mh64_pkg::KS0;
            state_d = S_INIT;
          end else begin
            state_d = S_DISP;
          end
        end
      end
      S_INIT: begin
        h_d = p + 64'(tot_q);
        for (int i = 0; i < 4; i++) begin
          lane_d[i] = p + 64'(tot_q);
        end
        state_d = S_DISP;
      end
      S_DISP: begin
        if (off_q >= tot_q) begin
          state_d = S_FIN;
        end else if (off_q < bulk_end) begin
          // Lane k of the stripe always sits in slot 0; the lane number picks the constant.
          mul_en  = 1'b1;
          mul_a   = d_q;
          mul_ks  = off_q[4:3];
          state_d = S_STRIPE;
        end else if (tot_q[4] && (post < LW'(16))) begin
          off_d = off_q + LW'(8);
          if (post == '0) begin
            pair_d  = d_q;
            state_d = S_FIN;
          end else begin
            mul_en  = 1'b1;
            mul_a   = pair_q;
            mul_ks  = mh64_pkg::KS0;
            state_d = S_P1;
          end
        end else if (rem >= LW'(8)) begin
          off_d   = off_q + LW'(8);
          mul_en  = 1'b1;
          mul_a   = d_q;
          mul_ks  = mh64_pkg::KS3;
          piece_d = mh64_pkg::PC_WORD;
          n_d     = 3'd0;
          state_d = S_TADD;
        end else begin
          off_d   = tot_q;
          n_d     = rem[2:0];
          state_d = S_TDISP;
        end
      end
      S_STRIPE: begin
        sum       = lane_q[0] + p;
        lane_d[0] = lane_q[1];
        lane_d[1] = lane_q[2];
        lane_d[2] = lane_q[3];
        lane_d[3] = mh64_pkg::rotr64(sum, 29) + lane_q[2];
        off_d     = off_q + LW'(8);
        if ((off_q + LW'(8)) == bulk_end) begin
          rnd_d   = '0;
          state_d = S_FA;
        end else begin
          state_d = S_FIN;
        end
      end
      S_P1: begin
        a_d     = h_q + p;
        mul_en  = 1'b1;
        mul_a   = d_q;
        mul_ks  = mh64_pkg::KS1;
        state_d = S_P2;
      end
      S_P2: begin
        b_d     = h_q + p;
        mul_en  = 1'b1;
        mul_a   = mh64_pkg::rotr64(a_q, 33);
        mul_ks  = mh64_pkg::KS1;
        state_d = S_P3;
      end
      S_P3: begin
        a_d     = p;
        mul_en  = 1'b1;
        mul_a   = mh64_pkg::rotr64(b_q, 33);
        mul_ks  = mh64_pkg::KS2;
        state_d = S_P4;
      end
      S_P4: begin
        b_d     = p;
        mul_en  = 1'b1;
        mul_a   = a_q;
        mul_ks  = mh64_pkg::KS0;
        state_d = S_P5;
      end
      S_P5: begin
        a_d     = a_q ^ (mh64_pkg::rotr64(p, 35) + b_q);
        mul_en  = 1'b1;
        mul_a   = b_q;
        mul_ks  = mh64_pkg::KS3;
        state_d = S_P6;
      end
      S_P6: begin
        h_d     = h_q + (b_q ^ (mh64_pkg::rotr64(p, 35) + a_q));
        state_d = S_FIN;
      end
      S_TDISP: begin
        if (n_q == 3'd0) begin
          state_d = S_FIN;
        end else begin
          piece_d = pc_sel;
          mul_en  = 1'b1;
          mul_a   = d_q & mh64_pkg::piece_mask(pc_sel);
          mul_ks  = mh64_pkg::KS3;
          state_d = S_TADD;
        end
      end
      S_TADD: begin
        hs      = h_q + p;
        h_d     = hs;
        mul_en  = 1'b1;
        mul_a   = mh64_pkg::rot_piece(hs, piece_q);
        mul_ks  = mh64_pkg::KS1;
        state_d = S_TXOR;
      end
      S_TXOR: begin
        h_d     = h_q ^ p;
        d_d     = mh64_pkg::shift_piece(d_q, piece_q);
        n_d     = n_q - mh64_pkg::piece_len(piece_q);
        state_d = S_TDISP;
      end
      S_FA: begin
        mul_en = 1'b1;
        case (rnd_q)
          2'd0: begin
            mul_a  = lane_q[0] + lane_q[3];
            mul_ks = mh64_pkg::KS0;
          end
          2'd1: begin
            mul_a  = lane_q[1] + lane_q[2];
            mul_ks = mh64_pkg::KS1;
          end
          2'd2: begin
            mul_a  = lane_q[0] + lane_q[2];
            mul_ks = mh64_pkg::KS0;
          end
          default: begin
            mul_a  = lane_q[1] + lane_q[3];
            mul_ks = mh64_pkg::KS1;
          end
        endcase
        state_d = S_FB;
      end
      S_FB: begin
        mul_en = 1'b1;
        case (rnd_q)
          2'd0: begin
            mul_a  = mh64_pkg::rotr64(p + lane_q[1], 33);
            mul_ks = mh64_pkg::KS1;
          end
          2'd1: begin
            mul_a  = mh64_pkg::rotr64(p + lane_q[0], 33);
            mul_ks = mh64_pkg::KS0;
          end
          2'd2: begin
            mul_a  = mh64_pkg::rotr64(p + lane_q[3], 33);
            mul_ks = mh64_pkg::KS1;
          end
          default: begin
            mul_a  = mh64_pkg::rotr64(p + lane_q[2], 33);
            mul_ks = mh64_pkg::KS0;
          end
        endcase
        state_d = S_FC;
      end
      S_FC: begin
        case (rnd_q)
          2'd0:    lane_d[2] = lane_q[2] ^ p;
          2'd1:    lane_d[3] = lane_q[3] ^ p;
          2'd2:    lane_d[0] = lane_q[0] ^ p;
          default: lane_d[1] = lane_q[1] ^ p;
        endcase
        if (rnd_q == LastRound) begin
          state_d = S_FH;
        end else begin
          rnd_d   = rnd_q + 2'd1;
          state_d = S_FA;
        end
      end
      S_FH: begin
        h_d     = h_q + (lane_q[0] ^ lane_q[1]);
        state_d = S_FIN;
      end
      S_FIN: begin
        if (last_q) begin
          mul_en  = 1'b1;
          mul_a   = h_q ^ mh64_pkg::rotr64(h_q, 33);
          mul_ks  = mh64_pkg::KS0;
          state_d = S_AV;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_AV: begin
        // The product holds here until the output register can take the hash.
        if (res_ready_i) begin
          res_o.valid = 1'b1;
          off_d       = tot_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      for (int i = 0; i < 4; i++) begin
        lane_q[i] <= '0;
      end
      h_q     <= '0;
      pair_q  <= '0;
      off_q   <= '0;
      tot_q   <= '0;
      last_q  <= 1'b0;
      n_q     <= '0;
      piece_q <= mh64_pkg::PC_WORD;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      lane_q  <= lane_d;
      h_q     <= h_d;
      pair_q  <= pair_d;
      off_q   <= off_d;
      tot_q   <= tot_d;
      last_q  <= last_d;
      n_q     <= n_d;
      piece_q <= piece_d;
      rnd_q   <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q <= d_d;
    a_q <= a_d;
    b_q <= b_d;
  end

  a_res_when_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> res_ready_i)
    else $error("hash produced while the output register is full");

  a_offset_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    off_q <= tot_q)
    else $error("byte offset ran past the message length");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second word accepted right behind the first");

  a_idle_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |=> in_ready_o)
    else $error("sequencer did not return to idle after a hash");

endmodule

@@ tb/metrohash64_stream_hasher_checker.sv @@
// Checker for the MetroHash64 stream hasher: watches the seed, word and hash channels.
// It keeps its own copy of the hash state, predicts every hash and compares it on arrival.
// Stand-alone module; it depends on nothing but its ports.
module metrohash64_stream_hasher_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        first_word_i,
  input  logic [31:0] message_length_i,
  input  logic [63:0] data_i,
  input  logic        last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [63:0] hash_value_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  localparam logic [63:0] MUL0 = 64'h0000_0000_C83A_91E1;
  localparam logic [63:0] MUL1 = 64'h0000_0000_8648_DBDB;
  localparam logic [63:0] MUL2 = 64'h0000_0000_7BDE_C03B;
  localparam logic [63:0] MUL3 = 64'h0000_0000_2F58_70A5;

  logic [63:0] seed_reg;
  logic [63:0] lane [4];
  logic [63:0] hash_acc;
  logic [63:0] pair_first;
  logic [31:0] bytes_taken;
  logic [31:0] msg_len;
  logic [63:0] hash_queue [$];
  logic [63:0] want;
  logic [63:0] fin;
  int unsigned mismatches;

  function automatic logic [63:0] ror(input logic [63:0] v, input int unsigned k);
    return (v >> k) | (v << (64 - k));
  endfunction

  // Adds one word to the running hash; the byte position decides which mix it gets.
  task automatic absorb_word(input logic [63:0] word);
    logic [31:0] remaining;
    logic [31:0] bulk_end;
    logic [31:0] post;
    logic [31:0] tail_len;
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] h;
    logic [63:0] d;
    logic [63:0] k;
    int unsigned idx;
    if (bytes_taken >= msg_len) return;
    remaining = msg_len - bytes_taken;
    bulk_end = msg_len & ~32'd31;
    d = word;
    if (bytes_taken < bulk_end) begin
      idx = bytes_taken[4:3];
      case (idx)
        0:       k = MUL0;
        1:       k = MUL1;
        2:       k = MUL2;
        default: k = MUL3;
      endcase
      lane[idx] = lane[idx] + d * k;
      lane[idx] = ror(lane[idx], 29) + lane[(idx + 2) % 4];
      bytes_taken = bytes_taken + 32'd8;
      if (bytes_taken == bulk_end) begin
        lane[2] ^= ror((lane[0] + lane[3]) * MUL0 + lane[1], 33) * MUL1;
        lane[3] ^= ror((lane[1] + lane[2]) * MUL1 + lane[0], 33) * MUL0;
        lane[0] ^= ror((lane[0] + lane[2]) * MUL0 + lane[3], 33) * MUL1;
        lane[1] ^= ror((lane[1] + lane[3]) * MUL1 + lane[2], 33) * MUL0;
        hash_acc = hash_acc + (lane[0] ^ lane[1]);
      end
      return;
    end
    post = bytes_taken - bulk_end;
    tail_len = msg_len - bulk_end;
    if (tail_len >= 32'd16 && post < 32'd16) begin
      if (post == 32'd0) begin
        pair_first = d;
      end else begin
        a = hash_acc + pair_first * MUL0;
        b = hash_acc + d * MUL1;
        a = ror(a, 33) * MUL1;
        b = ror(b, 33) * MUL2;
        a ^= ror(a * MUL0, 35) + b;
        b ^= ror(b * MUL3, 35) + a;
        hash_acc = hash_acc + b;
      end
      bytes_taken = bytes_taken + 32'd8;
    end else if (remaining >= 32'd8) begin
      hash_acc = hash_acc + d * MUL3;
      hash_acc ^= ror(hash_acc, 33) * MUL1;
      bytes_taken = bytes_taken + 32'd8;
    end else begin
      // Short tail: 4, 2 and 1 byte pieces, each with its own rotation.
      h = hash_acc;
      bytes_taken = msg_len;
      if (remaining >= 32'd4) begin
        h = h + (d & 64'h0000_0000_FFFF_FFFF) * MUL3;
        h ^= ror(h, 15) * MUL1;
        d = d >> 32;
        remaining = remaining - 32'd4;
      end
      if (remaining >= 32'd2) begin
        h = h + (d & 64'h0000_0000_0000_FFFF) * MUL3;
        h ^= ror(h, 13) * MUL1;
        d = d >> 16;
        remaining = remaining - 32'd2;
      end
      if (remaining >= 32'd1) begin
        h = h + (d & 64'h0000_0000_0000_00FF) * MUL3;
        h ^= ror(h, 25) * MUL1;
      end
      hash_acc = h;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_reg = '0;
      for (int i = 0; i < 4; i++) lane[i] = '0;
      hash_acc = '0;
      pair_first = '0;
      bytes_taken = '0;
      msg_len = '0;
      hash_queue.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      // Results are compared before this edge's word is absorbed; a hash never
      // leaves in the same cycle as the word that ends its message.
      if (out_valid_i && out_ready_i) begin
        if (hash_queue.size() == 0) begin
          mismatches++;
          $display("%0t: hash_value expected none, actual %016h", $time, hash_value_i);
        end else begin
          want = hash_queue.pop_front();
          if (hash_value_i !== want) begin
            mismatches++;
            $display("%0t: hash_value expected %016h, actual %016h",
                     $time, want, hash_value_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) seed_reg = cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        if (first_word_i) begin
          msg_len = message_length_i;
          bytes_taken = '0;
          pair_first = '0;
          hash_acc = (seed_reg + MUL2) * MUL0 + {32'd0, message_length_i};
          for (int i = 0; i < 4; i++) lane[i] = hash_acc;
        end
        absorb_word(data_i);
        if (last_i) begin
          fin = hash_acc;
          fin ^= ror(fin, 33);
          fin = fin * MUL0;
          fin ^= ror(fin, 33);
          hash_queue.push_back(fin);
          bytes_taken = msg_len;
        end
      end
      fail_count_o <= mismatches;
      pending_o <= hash_queue.size();
    end
  end

endmodule

@@ tb/metrohash64_stream_hasher_test.sv @@
// Top of the MetroHash64 stream hasher test: clock, reset, seed writes and message words.
// Depends on metrohash64_stream_hasher and metrohash64_stream_hasher_checker, which
// predicts and compares every hash; this module only drives stimulus and gives the verdict.
module metrohash64_stream_hasher_test;

  // Stimulus stops once about this many words have gone in.
  localparam int unsigned WORD_TARGET = 900;
  localparam int unsigned PHASES = 5;
  // Cycles without any handshake before the run is declared hung. The limit lies above
  // both the slowest word and the long output hold.
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned LONG_HOLD = 300;
  // A word without last may still be in the multiplier when the last hash has left.
  localparam int unsigned SETTLE = 40;

  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [63:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        first_word_i;
  logic [31:0] message_length_i;
  logic [63:0] data_i;
  logic [3:0]  byte_count_i;
  logic        last_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [63:0] hash_value_o;

  int unsigned fail_count;
  int unsigned hashes_pending;
  int unsigned words_sent = 0;
  int unsigned idle_cycles = 0;
  bit          quiet_phase = 1'b0;
  bit          sender_gaps = 1'b0;
  bit          hold_request = 1'b0;
  logic [63:0] seed_value;

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  metrohash64_stream_hasher dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .first_word_i     (first_word_i),
    .message_length_i (message_length_i),
    .data_i           (data_i),
    .byte_count_i     (byte_count_i),
    .last_i           (last_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .hash_value_o     (hash_value_o)
  );

  metrohash64_stream_hasher_checker hash_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .first_word_i     (first_word_i),
    .message_length_i (message_length_i),
    .data_i           (data_i),
    .last_i           (last_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .hash_value_i     (hash_value_o),
    .fail_count_o     (fail_count),
    .pending_o        (hashes_pending)
  );

  function automatic logic [63:0] fill_word(input fill_e fill);
    logic [63:0] w;
    case (fill)
      FILL_ONES:  w = '1;
      FILL_ZEROS: w = '0;
      default:    w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  // Offers one word and holds it until the hasher takes it. Valid is left high so
  // that back-to-back words go in without a bubble; a gap, when one is drawn, lowers
  // valid first and only then is the next word offered.
  task automatic send_word(input logic first, input logic [31:0] len, input logic [63:0] d,
                           input logic [3:0] bc, input logic fin);
    if (!quiet_phase && sender_gaps && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    first_word_i <= first;
    message_length_i <= len;
    data_i <= d;
    byte_count_i <= bc;
    last_i <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
  endtask

  // Sends the words of a message of the given length. A nonzero word limit cuts the
  // message short, and the last flag goes on the final word sent only when asked.
  task automatic send_message(input longint unsigned len, input fill_e fill,
                              input longint unsigned max_words, input bit close);
    longint unsigned n_words;
    longint unsigned left;
    logic [63:0] d;
    logic [3:0] bc;
    n_words = (len == 0) ? 1 : (len + 7) / 8;
    if (max_words != 0 && max_words < n_words) n_words = max_words;
    for (longint unsigned i = 0; i < n_words; i++) begin
      left = len - 8 * i;
      bc = (left >= 8) ? 4'd8 : 4'(left);
      d = fill_word(fill);
      // Bytes above the valid count must not matter; half the time they are cleared.
      if (fill == FILL_RANDOM && left < 8 && $urandom_range(0, 1) == 1)
        d = d & ((64'd1 << (8 * left)) - 64'd1);
      send_word(i == 0, len[31:0], d, bc, close && i == n_words - 1);
    end
  endtask

  // Words without first_word: they land past the declared length or after a last.
  task automatic send_stray_words(input int unsigned n, input bit close_on_final);
    logic fin;
    for (int unsigned i = 0; i < n; i++) begin
      if (i == n - 1) fin = close_on_final;
      else fin = ($urandom_range(0, 1) == 1);
      send_word(1'b0, $urandom, fill_word(FILL_RANDOM), 4'($urandom_range(0, 15)), fin);
    end
  endtask

  // Mostly short messages so the tail and pair paths get exercised, some that run
  // through several stripes, a few long ones.
  function automatic longint unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 64);
    if (r < 95) return $urandom_range(65, 160);
    return $urandom_range(161, 320);
  endfunction

  // Most messages are well formed with random content; the rest end too early,
  // run past their length, carry trailing words, or are lone noise words.
  task automatic send_random_message();
    int unsigned kind;
    longint unsigned len;
    kind = $urandom_range(0, 99);
    sender_gaps = ($urandom_range(0, 3) != 0);
    if (kind < 65) begin
      send_message(pick_length(), FILL_RANDOM, 0, 1'b1);
    end else if (kind < 77) begin
      len = ($urandom_range(0, 1) == 1) ? longint'($urandom) : pick_length() + 8;
      send_message(len, FILL_RANDOM, $urandom_range(1, 6), 1'b1);
    end else if (kind < 87) begin
      send_message(pick_length(), FILL_RANDOM, 0, 1'b0);
      send_stray_words($urandom_range(1, 3), 1'b1);
    end else if (kind < 95) begin
      send_message(pick_length(), FILL_RANDOM, 0, 1'b1);
      send_stray_words($urandom_range(1, 3), $urandom_range(0, 1) == 1);
    end else begin
      send_word($urandom_range(0, 1) == 1, $urandom, fill_word(FILL_RANDOM),
                4'($urandom_range(0, 15)), $urandom_range(0, 1) == 1);
    end
  endtask

  // The seed may only change while the hasher is idle: every expected hash has
  // been delivered and any word still in the multiplier has had time to finish.
  task automatic pause_and_seed(input logic [63:0] v);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (hashes_pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver: random ready stalls, a long hold on request so the hasher backs up
  // into its input, and steady ready in the final phase.
  initial begin
    forever begin
      if (hold_request) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_request = 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("metrohash64_stream_hasher_test NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    first_word_i <= 1'b0;
    message_length_i <= '0;
    data_i <= '0;
    byte_count_i <= '0;
    last_i <= 1'b0;
    sender_gaps = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed words, all under the reset seed of zero. The first one closes a
    // message that never had a first word, so the hash state is still all zero.
    send_word(1'b0, 32'd0, fill_word(FILL_RANDOM), 4'd8, 1'b1);
    send_message(0, FILL_RANDOM, 0, 1'b1);             // empty message
    send_message(1, FILL_ONES, 0, 1'b1);               // single byte piece
    send_message(7, FILL_RANDOM, 0, 1'b1);             // 4, 2 and 1 byte pieces
    send_message(12, FILL_ZEROS, 0, 1'b1);             // whole word plus 4 bytes
    send_message(16, FILL_RANDOM, 0, 1'b1);            // one 16-byte pair
    send_message(23, FILL_ONES, 0, 1'b1);              // pair then a 7-byte tail
    send_message(32, FILL_RANDOM, 0, 1'b1);            // one full stripe and the fold
    // Largest length, closed on its first word: the stripe is dropped unfinished.
    send_message(64'h0000_0000_FFFF_FFFF, FILL_ONES, 1, 1'b1);
    // A second last without a first word must return the same hash again.
    send_word(1'b0, 32'd0, fill_word(FILL_RANDOM), 4'd8, 1'b1);
    // One word past the declared length, carrying the last flag.
    send_message(8, FILL_RANDOM, 0, 1'b0);
    send_word(1'b0, $urandom, fill_word(FILL_RANDOM), 4'd8, 1'b1);

    // Random phases, each under its own seed, both extremes among them.
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       seed_value = '1;
        1:       seed_value = '0;
        default: seed_value = {$urandom, $urandom};
      endcase
      pause_and_seed(seed_value);
      quiet_phase = (phase == PHASES - 1);
      if (phase == 1) begin
        // Short messages against a receiver that holds off for a long time: the
        // output register fills, the next hash cannot leave and input stalls.
        hold_request = 1'b1;
        sender_gaps = 1'b0;
        repeat (24) send_message($urandom_range(0, 12), FILL_RANDOM, 0, 1'b1);
      end
      while (words_sent < 20 + (phase + 1) * ((WORD_TARGET - 20) / PHASES))
        send_random_message();
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (hashes_pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    if (fail_count == 0 && hashes_pending == 0) begin
      $display("metrohash64_stream_hasher_test OK");
    end else begin
      $display("metrohash64_stream_hasher_test NOT OK");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/mh64_pkg.sv
rtl/mh64_mul.sv
rtl/mh64_seq.sv
rtl/metrohash64_stream_hasher.sv
tb/metrohash64_stream_hasher_checker.sv
tb/metrohash64_stream_hasher_test.sv
